@@ hw/rtl/wca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wca_pkg
// Shared widths and types for the WCA pair force pipeline.
// ----------------------------------------------------------------------------
package wca_pkg;

  localparam int RW         = 24;  // input field width, also the multiply limb
  localparam int OUT_W      = 32;  // Q16.16 force component
  localparam int Q_W        = 33;  // quotient bits kept by the divider
  localparam int DIV_STAGES = Q_W + 1;  // overflow check plus one stage per bit

  // per-word flags that ride alongside the arithmetic
  typedef struct packed {
    logic r_zero;   // zero distance
    logic dneg_x;
    logic dneg_y;
    logic dz_x;     // delta x is zero
    logic dz_y;
    logic fneg;     // r^6 above one: attraction
    logic fzero;    // r^6 exactly one
  } side_t;

endpackage

@@ hw/rtl/wca_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wca_in_if / wca_out_if
// Valid/ready channels for pair words and force words.
// ----------------------------------------------------------------------------
interface wca_in_if;
  logic               valid;
  logic               ready;
  logic        [23:0] r_sq;
  logic signed [23:0] delta_x;
  logic signed [23:0] delta_y;

  modport source (output valid, output r_sq, output delta_x, output delta_y, input ready);
  modport sink   (input valid, input r_sq, input delta_x, input delta_y, output ready);
endinterface

interface wca_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic               saturated;

  modport source (output valid, output force_x, output force_y, output saturated,
                  input ready);
  modport sink   (input valid, input force_x, input force_y, input saturated,
                  output ready);
endinterface

@@ hw/rtl/wca_rmul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wca_rmul
// Two-stage multi-limb by 24-bit multiply: limb products, then one add.
// ----------------------------------------------------------------------------
module wca_rmul
  import wca_pkg::*;
#(
  parameter int LIMBS = 1
) (
  input  logic                   clk,
  input  logic                   en_a,
  input  logic                   en_b,
  input  logic [RW*LIMBS-1:0]    a,
  input  logic [RW-1:0]          b,
  output logic [RW*(LIMBS+1)-1:0] p
);

  logic [2*RW-1:0]         pp_r [LIMBS];
  logic [RW*(LIMBS+1)-1:0] ev;
  logic [RW*(LIMBS+1)-1:0] od;
  logic [RW*(LIMBS+1)-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < LIMBS; i++) begin
        pp_r[i] <= a[RW*i +: RW] * b;
      end
    end
  end

  // even and odd limb products do not overlap, so each side is a concat
  always_comb begin
    ev = '0;
    od = '0;
    for (int i = 0; i < LIMBS; i++) begin
      if ((i % 2) == 0) begin
        ev[RW*i +: 2*RW] = pp_r[i];
      end else begin
        od[RW*i +: 2*RW] = pp_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      p_r <= ev + od;
    end
  end

  assign p = p_r;

endmodule

@@ hw/rtl/wca_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wca_div
// Pipelined restoring divider, two lanes sharing one divisor.
// ----------------------------------------------------------------------------
module wca_div
  import wca_pkg::*;
#(
  parameter int WD    = 202,
  parameter int DEN_W = 168
) (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [WD-1:0]         n_x,
  input  logic [WD-1:0]         n_y,
  input  logic [DEN_W-1:0]      den,
  output logic [Q_W-1:0]        q_x,
  output logic [Q_W-1:0]        q_y
);

  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [WD-1:0]    n_r   [DIV_STAGES][2];
  logic [Q_W-1:0]   q_r   [DIV_STAGES][2];
  logic [WD-1:0]    n_in  [2];

  assign n_in[0] = n_x;
  assign n_in[1] = n_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      den_r[0] <= den;
    end
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_den
    always_ff @(posedge clk) begin
      if (en[s]) begin
        den_r[s] <= den_r[s-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [WD-1:0] dtop;
    assign dtop = WD'(den) << Q_W;

    // quotient too wide: force all ones, later steps can only OR bits in
    always_ff @(posedge clk) begin
      if (en[0]) begin
        n_r[0][l] <= n_in[l];
        q_r[0][l] <= (n_in[l] >= dtop) ? '1 : '0;
      end
    end

    for (genvar s = 1; s < DIV_STAGES; s++) begin : g_step
      localparam int K = DIV_STAGES - 1 - s;
      logic [WD-1:0] d;
      logic          ge;
      assign d  = WD'(den_r[s-1]) << K;
      assign ge = n_r[s-1][l] >= d;
      always_ff @(posedge clk) begin
        if (en[s]) begin
          n_r[s][l] <= ge ? (n_r[s-1][l] - d) : n_r[s-1][l];
          q_r[s][l] <= q_r[s-1][l] | (Q_W'(ge) << K);
        end
      end
    end
  end

  assign q_x = q_r[DIV_STAGES-1][0];
  assign q_y = q_r[DIV_STAGES-1][1];

endmodule

@@ hw/rtl/wca_pair_force.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wca_pair_force
// WCA repulsive pair force, f = 12*(1/r^6 - 1)/(r^6*r^2), times (dx, dy).
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       word
//  --------  ---  --------------  ------------------------------------------
//  in_chan   in   valid / ready   r_sq u24, delta_x s24, delta_y s24 (QF)
//  out_chan  out  valid / ready   force_x s32, force_y s32 (Q16.16), saturated
//
//  One word per cycle while out_chan.ready is high; 48 register stages, including
//  the 34-stage restoring divider that follows the r^14 power chain (six
//  two-stage multiplies).
//  Reset clears the valid bits only; ready is high the cycle after reset.
//  Every stage holds its word unless the next one is empty or moving, so
//  bubbles close up under an output stall and no word is lost or repeated.
//
//  Stage map:
//    0        input register, |delta| and flags
//    1..12    r^4 .. r^14, each a limb-product stage then an add stage
//    5        M = |2^(3F) - r^6|, sign of f
//    6..7     M * |dx|, M * |dy|
//    8        P = 12 * M * |d|
//    13..46   divide P * 2^(3F+16) by r^14
//    47       sign, clip to Q16.16, output register
// ----------------------------------------------------------------------------
module wca_pair_force
  import wca_pkg::*;
#(
  parameter int IN_FRAC_BITS = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  wca_in_if.sink           in_chan,
  wca_out_if.source        out_chan
);

  localparam int TH    = 3 * IN_FRAC_BITS;
  localparam int MW    = (TH + 1 > 3 * RW) ? TH + 1 : 3 * RW;
  localparam int ML    = (MW + RW - 1) / RW;
  localparam int PW    = RW * (ML + 1) + 4;
  localparam int SH    = TH + 16;
  localparam int NW    = PW + SH;
  localparam int DEN_W = 7 * RW;
  localparam int WD    = (NW > DEN_W + Q_W + 1) ? NW : DEN_W + Q_W + 1;
  localparam int S_M   = 5;
  localparam int S_P   = 8;
  localparam int S_DIV = 13;
  localparam int NS    = S_DIV + DIV_STAGES + 1;
  localparam logic [MW-1:0] ONE3 = MW'(1) << TH;

  // ---------------------------------------------------------------- control
  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  assign en[NS] = out_chan.ready;
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = !v_r[s] || en[s+1];
    if (s == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en[s]) begin
          v_r[s] <= in_chan.valid;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  assign in_chan.ready = en[0];

  // ---------------------------------------------------------- stage 0 input
  logic [RW-1:0] r_r    [0:S_DIV-2];
  logic [RW-1:0] magx_r [0:S_M];
  logic [RW-1:0] magy_r [0:S_M];
  side_t         side_r [0:NS-2];
  logic [RW-1:0] dxu;
  logic [RW-1:0] dyu;

  assign dxu = in_chan.delta_x;
  assign dyu = in_chan.delta_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r[0]           <= in_chan.r_sq;
      magx_r[0]        <= dxu[RW-1] ? (~dxu + RW'(1)) : dxu;
      magy_r[0]        <= dyu[RW-1] ? (~dyu + RW'(1)) : dyu;
      side_r[0].r_zero <= (in_chan.r_sq == '0);
      side_r[0].dneg_x <= dxu[RW-1];
      side_r[0].dneg_y <= dyu[RW-1];
      side_r[0].dz_x   <= (dxu == '0);
      side_r[0].dz_y   <= (dyu == '0);
      side_r[0].fneg   <= 1'b0;
      side_r[0].fzero  <= 1'b0;
    end
  end

  for (genvar s = 1; s < S_DIV - 1; s++) begin : g_rdly
    always_ff @(posedge clk) begin
      if (en[s]) begin
        r_r[s] <= r_r[s-1];
      end
    end
  end

  for (genvar s = 1; s <= S_M; s++) begin : g_mdly
    always_ff @(posedge clk) begin
      if (en[s]) begin
        magx_r[s] <= magx_r[s-1];
        magy_r[s] <= magy_r[s-1];
      end
    end
  end

  // power chain r^2 .. r^14
  logic [DEN_W-1:0] pw [1:7];   // pw[j] = r^(2j), valid at stage 2j-2
  logic [MW-1:0]    r3e;
  logic             fneg_nxt;

  assign pw[1] = DEN_W'(r_r[0]);

  for (genvar j = 1; j <= 6; j++) begin : g_pow
    logic [RW*(j+1)-1:0] prod;
    wca_rmul #(.LIMBS(j)) u_rmul (
      .clk  (clk),
      .en_a (en[2*j-1]),
      .en_b (en[2*j]),
      .a    (pw[j][RW*j-1:0]),
      .b    (r_r[2*j-2]),
      .p    (prod)
    );
    assign pw[j+1] = DEN_W'(prod);
  end

  // side flags pass along; stage 5 fills in the sign of f and its zero flag
  assign r3e      = MW'(pw[3][3*RW-1:0]);
  assign fneg_nxt = r3e > ONE3;

  for (genvar s = 1; s < NS - 1; s++) begin : g_side
    if (s == S_M) begin : g_sgn
      side_t side_nxt;
      always_comb begin
        side_nxt       = side_r[s-1];
        side_nxt.fneg  = fneg_nxt;
        side_nxt.fzero = (r3e == ONE3);
      end
      always_ff @(posedge clk) begin
        if (en[s]) begin
          side_r[s] <= side_nxt;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en[s]) begin
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  // ------------------------------------------------------ numerator M*|d|*12
  logic [MW-1:0]         m_r;
  logic [RW*(ML+1)-1:0]  mmx;
  logic [RW*(ML+1)-1:0]  mmy;
  logic [PW-1:0]         px_r [S_P:S_DIV-1];
  logic [PW-1:0]         py_r [S_P:S_DIV-1];

  always_ff @(posedge clk) begin
    if (en[S_M]) begin
      m_r <= fneg_nxt ? (r3e - ONE3) : (ONE3 - r3e);
    end
  end

  wca_rmul #(.LIMBS(ML)) u_mulx (
    .clk  (clk),
    .en_a (en[S_M+1]),
    .en_b (en[S_M+2]),
    .a    ((RW*ML)'(m_r)),
    .b    (magx_r[S_M]),
    .p    (mmx)
  );

  wca_rmul #(.LIMBS(ML)) u_muly (
    .clk  (clk),
    .en_a (en[S_M+1]),
    .en_b (en[S_M+2]),
    .a    ((RW*ML)'(m_r)),
    .b    (magy_r[S_M]),
    .p    (mmy)
  );

  always_ff @(posedge clk) begin
    if (en[S_P]) begin
      px_r[S_P] <= (PW'(mmx) << 3) + (PW'(mmx) << 2);
      py_r[S_P] <= (PW'(mmy) << 3) + (PW'(mmy) << 2);
    end
  end

  for (genvar s = S_P + 1; s < S_DIV; s++) begin : g_pdly
    always_ff @(posedge clk) begin
      if (en[s]) begin
        px_r[s] <= px_r[s-1];
        py_r[s] <= py_r[s-1];
      end
    end
  end

  // ------------------------------------------------------------- divider
  logic [Q_W-1:0] qx;
  logic [Q_W-1:0] qy;

  wca_div #(.WD(WD), .DEN_W(DEN_W)) u_div (
    .clk (clk),
    .en  (en[S_DIV +: DIV_STAGES]),
    .n_x (WD'(px_r[S_DIV-1]) << SH),
    .n_y (WD'(py_r[S_DIV-1]) << SH),
    .den (pw[7]),
    .q_x (qx),
    .q_y (qy)
  );

  // ------------------------------------------------------- sign and clip
  // returns {clipped, value}; negative side reaches -2^31 without a clip
  function automatic logic [OUT_W:0] clip_enc(input logic neg, input logic [Q_W-1:0] q);
    logic [Q_W-1:0]   lim;
    logic             clp;
    logic [OUT_W-1:0] mag;
    lim = neg ? (Q_W'(1) << (OUT_W - 1)) : ((Q_W'(1) << (OUT_W - 1)) - Q_W'(1));
    clp = q > lim;
    mag = clp ? lim[OUT_W-1:0] : q[OUT_W-1:0];
    return {clp, neg ? (~mag + OUT_W'(1)) : mag};
  endfunction

  side_t          sd;
  logic [OUT_W:0] ex;
  logic [OUT_W:0] ey;
  logic [OUT_W-1:0] fx_r;
  logic [OUT_W-1:0] fy_r;
  logic             sat_r;

  assign sd = side_r[NS-2];
  assign ex = (sd.dz_x || sd.fzero) ? '0 : clip_enc(sd.fneg ^ sd.dneg_x, qx);
  assign ey = (sd.dz_y || sd.fzero) ? '0 : clip_enc(sd.fneg ^ sd.dneg_y, qy);

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      fx_r  <= ex[OUT_W-1:0];
      fy_r  <= ey[OUT_W-1:0];
      sat_r <= sd.r_zero | ex[OUT_W] | ey[OUT_W];
    end
  end

  assign out_chan.valid     = v_r[NS-1];
  assign out_chan.force_x   = fx_r;
  assign out_chan.force_y   = fy_r;
  assign out_chan.saturated = sat_r;

endmodule

@@ hw/rtl/wca_pair_force_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wca_pair_force_chk
// Port-level checks for the WCA pair force block, bound to the top level.
// ----------------------------------------------------------------------------
module wca_pair_force_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] force_x,
  input logic [31:0] force_y,
  input logic        saturated
);

  // a waiting word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(force_x) && $stable(force_y) && $stable(saturated))
    else $error("output word changed while stalled");

  // a free output end means every stage can move, so input must be open
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked with a free output");

  a_rst_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_rst_ready: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_ready)
    else $error("input not ready right after reset");

endmodule

bind wca_pair_force wca_pair_force_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .force_x   (out_chan.force_x),
  .force_y   (out_chan.force_y),
  .saturated (out_chan.saturated)
);
